[hdl/pkd_pkg.sv]
package pkd_pkg;

    // Field widths of the request and result items.
    localparam int C_VALUE_W     = 64;
    localparam int C_PREC_W      = 5;
    localparam int C_NIB_W       = 4;
    localparam int C_BYTE_W      = 8;
    localparam int C_POS_W       = 4;
    localparam int C_IN_DATA_W   = 80;
    localparam int C_OUT_DATA_W  = 16;
    localparam int C_CFG_IDX_W   = 2;

    // Signed nibble cursor: covers the top nibble down past the sign nibble.
    localparam int C_CUR_W = 7;

    // Parameter defaults.
    localparam int C_MAX_PRECISION = 31;
    localparam int C_VALUE_WIDTH   = 64;

    // Register indexes and reset values.
    localparam logic [C_CFG_IDX_W-1:0] C_REG_PLUS  = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_MINUS = 2'd1;
    localparam logic [C_NIB_W-1:0]     C_PLUS_RST  = 4'd12;
    localparam logic [C_NIB_W-1:0]     C_MINUS_RST = 4'd13;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_DABBLE,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [C_PREC_W-1:0]   avail;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_CHECK,
        S_ALIGN,
        S_NIB_HI,
        S_NIB_LO
    } t_state;

endpackage

[hdl/integer_to_packed_decimal.sv]
// Converts a signed integer to packed decimal with a trailing sign nibble.
// A request carries value, precision and scale; the block answers with
// precision/2+1 bytes, most significant first, tlast on the byte that holds
// the sign, and tuser set on every byte when the integral digits do not fit
// (the bytes are then zero digits with the plus sign). The conversion runs
// through a row of N_DIGITS BCD digit cells (20 for a 64-bit value), one bit
// of the magnitude per cycle. A request is taken, converted, checked for
// overflow, and its digits are shifted to line up with the scale; each result
// byte is then built in a high-nibble and a low-nibble step, and the
// low-nibble step waits while the result side holds tready low. The next
// request is taken once the last byte has entered the output register.
module integer_to_packed_decimal import pkd_pkg::*; #(
    parameter int MAX_PRECISION = C_MAX_PRECISION,
    parameter int VALUE_WIDTH   = C_VALUE_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // value [63:0], precision [68:64], scale [73:69], zero fill above
    input  logic [C_IN_DATA_W-1:0]   i_s_tdata,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // packed_byte [7:0], byte_position [11:8], zero fill above
    output logic [C_OUT_DATA_W-1:0]  o_m_tdata,
    // overflow [0]
    output logic                     o_m_tuser,
    output logic                     o_m_tlast,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [C_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [C_NIB_W-1:0]       i_cfg_data
);

    localparam int N_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int CNT_W    = $clog2(VALUE_WIDTH);

    t_state                    r_state, n_state;
    logic [C_NIB_W-1:0]        r_plus, r_minus;
    logic [VALUE_WIDTH-1:0]    r_mag, n_mag;
    logic                      r_neg, n_neg;
    logic [C_PREC_W-1:0]       r_prec, n_prec;
    logic [C_PREC_W-1:0]       r_scale, n_scale;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      r_ovf, n_ovf;
    logic signed [C_CUR_W-1:0] r_e, n_e;
    logic signed [C_CUR_W-1:0] r_t, n_t;
    logic [C_POS_W-1:0]        r_byte, n_byte;
    logic [C_NIB_W-1:0]        r_hi, n_hi;

    logic                      r_out_valid, n_out_valid;
    logic [C_BYTE_W-1:0]       r_out_byte, n_out_byte;
    logic [C_POS_W-1:0]        r_out_pos, n_out_pos;
    logic                      r_out_last, n_out_last;
    logic                      r_out_ovf, n_out_ovf;

    t_cell_ctrl                w_ctrl;
    t_cell_op                  w_op;
    logic [C_PREC_W-1:0]       w_avail;
    logic [C_NIB_W-1:0]        w_digit  [N_DIGITS];
    logic                      w_carry  [N_DIGITS];
    logic [N_DIGITS-1:0]       w_excess;

    logic [VALUE_WIDTH-1:0]    w_raw;
    logic [C_PREC_W-1:0]       w_in_prec;
    logic [C_PREC_W-1:0]       w_in_scale;
    logic                      w_slot_free;
    logic                      w_last;
    logic [C_NIB_W-1:0]        w_top;
    logic [C_NIB_W-1:0]        w_sign;
    logic [C_PREC_W-1:0]       w_top_nib;

    assign w_raw      = i_s_tdata[VALUE_WIDTH-1:0];
    assign w_in_prec  = i_s_tdata[C_VALUE_W +: C_PREC_W];
    assign w_in_scale = i_s_tdata[C_VALUE_W + C_PREC_W +: C_PREC_W];

    assign w_slot_free = !r_out_valid || i_m_tready;
    assign w_last      = (r_byte == r_prec[C_PREC_W-1:1]);
    assign w_top       = w_digit[N_DIGITS-1];
    assign w_sign      = (r_neg && !r_ovf) ? r_minus : r_plus;
    assign w_top_nib   = {r_prec[C_PREC_W-1:1], 1'b1};

    assign w_avail = (r_prec >= r_scale) ? r_prec - r_scale : '0;

    always_comb begin
        w_ctrl.op    = w_op;
        w_ctrl.avail = w_avail;
    end

    // Digit row: cell 0 holds the units digit and takes the magnitude's MSB.
    for (genvar g = 0; g < N_DIGITS; g++) begin : g_cell
        logic               w_cin;
        logic [C_NIB_W-1:0] w_din;
        if (g == 0) begin : g_first
            assign w_cin = r_mag[VALUE_WIDTH-1];
            assign w_din = '0;
        end else begin : g_rest
            assign w_cin = w_carry[g-1];
            assign w_din = w_digit[g-1];
        end
        pkd_digit_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_carry  (w_cin),
            .i_digit  (w_din),
            .o_carry  (w_carry[g]),
            .o_digit  (w_digit[g]),
            .o_excess (w_excess[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_prec      = r_prec;
        n_scale     = r_scale;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_e         = r_e;
        n_t         = r_t;
        n_byte      = r_byte;
        n_hi        = r_hi;
        n_out_byte  = r_out_byte;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        n_out_valid = r_out_valid && !i_m_tready;
        w_op        = OP_HOLD;
        o_s_tready  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_neg   = w_raw[VALUE_WIDTH-1];
                    n_mag   = w_raw[VALUE_WIDTH-1] ? '0 - w_raw : w_raw;
                    n_prec  = (w_in_prec > C_PREC_W'(MAX_PRECISION)) ?
                              C_PREC_W'(MAX_PRECISION) : w_in_prec;
                    n_scale = w_in_scale;
                    n_cnt   = CNT_W'(VALUE_WIDTH - 1);
                    w_op    = OP_CLEAR;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                w_op  = OP_DABBLE;
                n_mag = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_ovf   = |w_excess;
                n_e     = $signed({2'b00, w_top_nib}) - $signed({2'b00, r_scale})
                          - C_CUR_W'(1);
                n_t     = C_CUR_W'(N_DIGITS - 1);
                n_byte  = '0;
                n_state = S_ALIGN;
            end
            S_ALIGN: begin
                // The top cell is brought down to the digit that the first
                // nibble needs; digits shifted out are zero unless overflow.
                if (r_ovf || r_e < 0) begin
                    w_op    = OP_CLEAR;
                    n_t     = r_e;
                    n_state = S_NIB_HI;
                end else if (r_t > r_e) begin
                    w_op = OP_SHIFT;
                    n_t  = r_t - C_CUR_W'(1);
                end else begin
                    n_state = S_NIB_HI;
                end
            end
            S_NIB_HI: begin
                if (r_e == r_t) begin
                    n_hi = w_top;
                    w_op = OP_SHIFT;
                    n_t  = r_t - C_CUR_W'(1);
                end else begin
                    n_hi = '0;
                end
                n_e     = r_e - C_CUR_W'(1);
                n_state = S_NIB_LO;
            end
            S_NIB_LO: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = r_byte;
                    n_out_last  = w_last;
                    n_out_ovf   = r_ovf;
                    if (w_last) begin
                        n_out_byte = {r_hi, w_sign};
                        n_state    = S_IDLE;
                    end else begin
                        if (r_e == r_t) begin
                            n_out_byte = {r_hi, w_top};
                            w_op       = OP_SHIFT;
                            n_t        = r_t - C_CUR_W'(1);
                        end else begin
                            n_out_byte = {r_hi, {C_NIB_W{1'b0}}};
                        end
                        n_e     = r_e - C_CUR_W'(1);
                        n_byte  = r_byte + 1'b1;
                        n_state = S_NIB_HI;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_prec     <= n_prec;
        r_scale    <= n_scale;
        r_cnt      <= n_cnt;
        r_ovf      <= n_ovf;
        r_e        <= n_e;
        r_t        <= n_t;
        r_byte     <= n_byte;
        r_hi       <= n_hi;
        r_out_byte <= n_out_byte;
        r_out_pos  <= n_out_pos;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    // Sign code registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus  <= C_PLUS_RST;
            r_minus <= C_MINUS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                C_REG_PLUS:  r_plus  <= i_cfg_data;
                C_REG_MINUS: r_minus <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {{(C_OUT_DATA_W - C_BYTE_W - C_POS_W){1'b0}}, r_out_pos, r_out_byte};
    assign o_m_tlast   = r_out_last;
    assign o_m_tuser   = r_out_ovf;

endmodule

[hdl/pkd_digit_cell.sv]
module pkd_digit_cell import pkd_pkg::*; #(
    parameter int CELL_INDEX = 0
) (
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic               i_carry,
    input  logic [C_NIB_W-1:0] i_digit,
    output logic               o_carry,
    output logic [C_NIB_W-1:0] o_digit,
    output logic               o_excess
);

    localparam logic [C_PREC_W:0] L_INDEX = (C_PREC_W+1)'(CELL_INDEX);

    logic [C_NIB_W-1:0] r_digit;
    logic [C_NIB_W-1:0] n_digit;
    logic [C_NIB_W-1:0] w_adj;

    // Add three before the doubling so that the digit carries at ten.
    assign w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = w_adj[C_NIB_W-1];
    assign o_digit = r_digit;

    // A nonzero digit at or above the integral room is an overflow.
    assign o_excess = (r_digit != '0) && (L_INDEX >= {1'b0, i_ctrl.avail});

    always_comb begin
        unique case (i_ctrl.op)
            OP_HOLD:   n_digit = r_digit;
            OP_CLEAR:  n_digit = '0;
            OP_DABBLE: n_digit = {w_adj[C_NIB_W-2:0], i_carry};
            OP_SHIFT:  n_digit = i_digit;
            default:   n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import pkd_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int GAP_PERCENT  = 38;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [C_BYTE_W-1:0] packed_byte;
        logic [C_POS_W-1:0]  position;
        logic                last;
        logic                ovf;
    } t_digit_byte;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic [C_IN_DATA_W-1:0]  s_tdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [C_OUT_DATA_W-1:0] m_tdata;
    logic                    m_tuser;
    logic                    m_tlast;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [C_CFG_IDX_W-1:0]  cfg_index = '0;
    logic [C_NIB_W-1:0]      cfg_data = '0;

    logic                    gaps_on = 1'b1;
    logic                    stall_ask = 1'b0;
    int                      stall_left = 0;
    int                      errors = 0;
    int                      cycle_count = 0;

    // Sign codes as the block should hold them.
    logic [C_NIB_W-1:0]      plus_code = C_PLUS_RST;
    logic [C_NIB_W-1:0]      minus_code = C_MINUS_RST;

    t_digit_byte             expected_bytes[$];

    integer_to_packed_decimal dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever begin
            #CLK_HALF clk = ~clk;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[integer_to_packed_decimal] ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    always @(posedge clk) begin
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_ask) begin
            m_tready <= 1'b0;
            stall_left <= HOLD_CYCLES;
        end else if (gaps_on) begin
            m_tready <= ($urandom_range(99) >= GAP_PERCENT);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin
        t_digit_byte want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected byte, expected none, actual %0h", $time, m_tdata);
            end else begin
                want = expected_bytes.pop_front();
                check_field("packed_byte", want.packed_byte, m_tdata[7:0]);
                check_field("byte_position", 8'(want.position), 8'(m_tdata[11:8]));
                check_field("last_byte", 8'(want.last), 8'(m_tlast));
                check_field("overflow", 8'(want.ovf), 8'(m_tuser));
            end
        end
    end

    // Packed decimal expected for one request, nibble 0 being the sign.
    task automatic predict_packed(input logic [63:0] value, input logic [4:0] prec,
                                  input logic [4:0] scale);
        logic [3:0]  nib [0:33];
        logic [63:0] mag;
        logic        neg;
        logic        ovf;
        int          pos;
        int          nbytes;
        int          lo;
        t_digit_byte item;
        neg = value[63];
        mag = neg ? -value : value;
        foreach (nib[k]) nib[k] = '0;
        nib[0] = neg ? minus_code : plus_code;
        pos = int'(scale) + 1;
        while (mag != 0 && pos <= int'(prec)) begin
            nib[pos] = 4'(mag % 10);
            mag = mag / 10;
            pos++;
        end
        ovf = (mag != 0);
        if (ovf) begin
            foreach (nib[k]) nib[k] = '0;
            nib[0] = plus_code;
        end
        nbytes = int'(prec) / 2 + 1;
        for (int j = 0; j < nbytes; j++) begin
            lo = 2 * (nbytes - 1 - j);
            item.packed_byte = {nib[lo + 1], nib[lo]};
            item.position = C_POS_W'(j);
            item.last = (j == nbytes - 1);
            item.ovf = ovf;
            expected_bytes.push_back(item);
        end
    endtask

    task automatic send_request(input logic [63:0] value, input logic [4:0] prec,
                                input logic [4:0] scale);
        while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata <= {6'b0, scale, prec, value};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_packed(value, prec, scale);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] index, input logic [C_NIB_W-1:0] data);
        cfg_index <= index;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (index == C_REG_PLUS) plus_code = data;
        else if (index == C_REG_MINUS) minus_code = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly values that fit their precision and scale; the rest are noise
    // and the awkward corners.
    task automatic random_request();
        logic [63:0] value;
        logic [63:0] limit;
        int          prec;
        int          scale;
        int          digits;
        int          kind;
        kind = $urandom_range(99);
        if (kind < 65) begin
            prec = $urandom_range(31, 1);
            scale = $urandom_range(prec, 0);
            digits = $urandom_range((prec - scale > 19) ? 19 : prec - scale, 0);
            limit = 1;
            for (int k = 0; k < digits; k++) limit = limit * 10;
            value = random_word() % limit;
            if ($urandom_range(1)) value = -value;
        end else if (kind < 85) begin
            value = random_word();
            prec = $urandom_range(31);
            scale = $urandom_range(31);
        end else begin
            case ($urandom_range(4))
                0: value = 64'h8000_0000_0000_0000;
                1: value = 64'h7fff_ffff_ffff_ffff;
                2: value = '0;
                3: value = '1;
                default: value = 64'($signed($urandom_range(200)) - 100);
            endcase
            prec = $urandom_range(31);
            scale = $urandom_range(31);
        end
        send_request(value, 5'(prec), 5'(scale));
    endtask

    task automatic test_directed();
        send_request(64'd0, 5'd1, 5'd0);
        send_request(64'd0, 5'd0, 5'd0);
        send_request(64'd5, 5'd0, 5'd0);
        send_request(-64'd1, 5'd1, 5'd0);
        send_request(64'd9, 5'd1, 5'd0);
        send_request(64'd10, 5'd1, 5'd0);
        send_request(-64'd9, 5'd2, 5'd0);
        send_request(64'd99, 5'd2, 5'd0);
        send_request(64'd12345, 5'd5, 5'd2);
        send_request(64'd7, 5'd3, 5'd5);
        send_request(64'd0, 5'd3, 5'd5);
        send_request(64'h7fff_ffff_ffff_ffff, 5'd19, 5'd0);
        send_request(64'h7fff_ffff_ffff_ffff, 5'd31, 5'd0);
        send_request(64'h8000_0000_0000_0000, 5'd31, 5'd0);
        send_request(64'h8000_0000_0000_0000, 5'd19, 5'd0);
        send_request(64'h8000_0000_0000_0000, 5'd18, 5'd0);
        send_request(64'h7fff_ffff_ffff_ffff, 5'd31, 5'd12);
        send_request(64'h7fff_ffff_ffff_ffff, 5'd31, 5'd13);
        send_request(-64'd123456789, 5'd31, 5'd31);
        send_request(64'd0, 5'd31, 5'd31);
        send_request(64'd1, 5'd31, 5'd30);
        send_request(-64'd42, 5'd4, 5'd1);
        send_request(64'd1234567890, 5'd30, 5'd20);
    endtask

    task automatic test_sign_codes();
        logic [C_NIB_W-1:0] plus_set [4];
        logic [C_NIB_W-1:0] minus_set [4];
        plus_set = '{4'd0, 4'd15, 4'($urandom), 4'd7};
        minus_set = '{4'd15, 4'd0, 4'($urandom), 4'd7};
        for (int k = 0; k < 4; k++) begin
            wait_idle();
            write_reg(C_REG_PLUS, plus_set[k]);
            write_reg(C_REG_MINUS, minus_set[k]);
            repeat (25) random_request();
        end
        wait_idle();
        write_reg(C_REG_PLUS, C_PLUS_RST);
        write_reg(C_REG_MINUS, C_MINUS_RST);
    endtask

    // The result side holds off for a long while; the input has to stall.
    task automatic test_back_pressure();
        stall_ask <= 1'b1;
        @(posedge clk);
        stall_ask <= 1'b0;
        repeat (8) random_request();
        wait_idle();
    endtask

    task automatic test_no_gaps();
        gaps_on <= 1'b0;
        @(posedge clk);
        repeat (60) random_request();
        wait_idle();
        gaps_on <= 1'b1;
        @(posedge clk);
    endtask

    task automatic test_random();
        repeat (190) random_request();
        wait_idle();
    endtask

    initial begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_sign_codes();
        test_back_pressure();
        test_no_gaps();
        test_random();
        wait_idle();
        if (expected_bytes.size() != 0) begin
            errors++;
            $display("%0t: %0d bytes never arrived", $time, expected_bytes.size());
        end
        if (errors == 0) begin
            $display("[integer_to_packed_decimal] OK");
        end else begin
            $display("[integer_to_packed_decimal] ERROR");
        end
        $finish;
    end

endmodule
